// ===== hdl/dnsa_pkg.sv =====
package dnsa_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 16;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_RESP = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RCODE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_A     = 3'd5;

    // Header byte positions
    localparam logic [3:0] HDR_FLAGS_HI = 4'd2;
    localparam logic [3:0] HDR_FLAGS_LO = 4'd3;
    localparam logic [3:0] HDR_QD_HI    = 4'd4;
    localparam logic [3:0] HDR_QD_LO    = 4'd5;
    localparam logic [3:0] HDR_AN_HI    = 4'd6;
    localparam logic [3:0] HDR_AN_LO    = 4'd7;
    localparam logic [3:0] HDR_LAST     = 4'd11;

    // Answer fixed-field byte positions
    localparam logic [3:0] AF_TYPE_HI  = 4'd0;
    localparam logic [3:0] AF_TYPE_LO  = 4'd1;
    localparam logic [3:0] AF_CLASS_HI = 4'd2;
    localparam logic [3:0] AF_CLASS_LO = 4'd3;
    localparam logic [3:0] AF_TTL_0    = 4'd4;
    localparam logic [3:0] AF_TTL_1    = 4'd5;
    localparam logic [3:0] AF_TTL_2    = 4'd6;
    localparam logic [3:0] AF_TTL_3    = 4'd7;
    localparam logic [3:0] AF_RDLEN_HI = 4'd8;
    localparam logic [3:0] AF_LAST     = 4'd9;

    localparam logic [3:0] QF_LAST     = 4'd3;

    localparam logic [BYTE_W-1:0]  PTR_MASK   = 8'hC0;
    localparam logic [COUNT_W-1:0] QR_BIT     = 16'h8000;
    localparam logic [COUNT_W-1:0] RCODE_MASK = 16'h000F;
    localparam logic [COUNT_W-1:0] TYPE_A     = 16'd1;
    localparam logic [COUNT_W-1:0] CLASS_IN   = 16'd1;

    localparam logic [3:0] PTR_MARK   = 4'd1;
    localparam logic [3:0] RD_FIRST   = 4'd1;
    localparam logic [3:0] RD_A_LEN   = 4'd4;
    localparam logic [3:0] RD_CAP     = 4'd5;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   address;
        logic [WORD_W-1:0]   time_to_live;
    } result_t;

endpackage

// ===== hdl/dnsa_in_stage.sv =====
module dnsa_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dnsa_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    input  logic                          take,
    output logic                          held_valid,
    output logic [dnsa_pkg::BYTE_W-1:0]   held_byte,
    output logic                          held_last
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [dnsa_pkg::BYTE_W-1:0] byte_reg;
    logic                        last_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: capture on every accepted beat
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

endmodule

// ===== hdl/dnsa_parse.sv =====
module dnsa_parse (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [dnsa_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    output dnsa_pkg::result_t             result
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QFIXED,
        PH_ANAME,
        PH_AFIXED,
        PH_RDATA,
        PH_DONE
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [3:0]                          header_index_reg, header_index_next;
    logic [3:0]                          field_index_reg, field_index_next;
    logic [dnsa_pkg::COUNT_W-1:0]        questions_left_reg, questions_left_next;
    logic [dnsa_pkg::COUNT_W-1:0]        answers_left_reg, answers_left_next;
    logic [dnsa_pkg::COUNT_W-1:0]        skip_count_reg, skip_count_next;
    logic [dnsa_pkg::STATUS_W-1:0]       error_code_reg, error_code_next;
    logic [dnsa_pkg::COUNT_W-1:0]        flag_word_reg, flag_word_next;
    logic [dnsa_pkg::COUNT_W-1:0]        record_type_reg, record_type_next;
    logic [dnsa_pkg::COUNT_W-1:0]        record_class_reg, record_class_next;
    logic [dnsa_pkg::WORD_W-1:0]         record_ttl_reg, record_ttl_next;
    logic [dnsa_pkg::WORD_W-1:0]         address_reg, address_next;

    logic                                go_answers;
    logic [dnsa_pkg::COUNT_W-1:0]        ans_count;
    logic [3:0]                          fi_eff;
    logic [dnsa_pkg::COUNT_W-1:0]        skip_dec;
    logic [dnsa_pkg::COUNT_W-1:0]        rdlen;
    logic                                is_a_in;
    logic                                is_name;

    always_comb
    begin
        phase_next          = phase_reg;
        header_index_next   = header_index_reg;
        field_index_next    = field_index_reg;
        questions_left_next = questions_left_reg;
        answers_left_next   = answers_left_reg;
        skip_count_next     = skip_count_reg;
        error_code_next     = error_code_reg;
        flag_word_next      = flag_word_reg;
        record_type_next    = record_type_reg;
        record_class_next   = record_class_reg;
        record_ttl_next     = record_ttl_reg;
        address_next        = address_reg;
        go_answers          = 1'b0;
        ans_count           = answers_left_reg;
        skip_dec            = skip_count_reg - 1'b1;
        rdlen               = {skip_count_reg[15:8], data_byte};
        is_a_in             = (record_type_reg == dnsa_pkg::TYPE_A)
                              && (record_class_reg == dnsa_pkg::CLASS_IN);
        is_name             = (phase_reg == PH_QNAME) || (phase_reg == PH_ANAME);
        // rdata byte count starts at one on the first rdata beat
        fi_eff = ((phase_reg == PH_RDATA) && (field_index_reg == '0))
                 ? dnsa_pkg::RD_FIRST : field_index_reg;

        // Name walk shared by question and answer names
        if (is_name)
        begin
            if ((field_index_reg == dnsa_pkg::PTR_MARK)
                || ((skip_count_reg == '0) && (data_byte == '0)))
            begin
                phase_next       = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                skip_count_next  = '0;
                field_index_next = '0;
            end
            else if (skip_count_reg != '0)
            begin
                skip_count_next = skip_dec;
            end
            else if ((data_byte & dnsa_pkg::PTR_MASK) == dnsa_pkg::PTR_MASK)
            begin
                field_index_next = dnsa_pkg::PTR_MARK;
            end
            else
            begin
                skip_count_next = {{(dnsa_pkg::COUNT_W-dnsa_pkg::BYTE_W){1'b0}}, data_byte};
            end
        end

        unique case (phase_reg)
            PH_HEADER:
            begin
                case (header_index_reg)
                    dnsa_pkg::HDR_FLAGS_HI: flag_word_next[15:8]      = data_byte;
                    dnsa_pkg::HDR_FLAGS_LO: flag_word_next[7:0]       = data_byte;
                    dnsa_pkg::HDR_QD_HI:    questions_left_next[15:8] = data_byte;
                    dnsa_pkg::HDR_QD_LO:    questions_left_next[7:0]  = data_byte;
                    dnsa_pkg::HDR_AN_HI:    answers_left_next[15:8]   = data_byte;
                    dnsa_pkg::HDR_AN_LO:    answers_left_next[7:0]    = data_byte;
                    default: ;
                endcase
                header_index_next = header_index_reg + 1'b1;
                if (header_index_reg == dnsa_pkg::HDR_LAST)
                begin
                    if ((flag_word_reg & dnsa_pkg::QR_BIT) == '0)
                    begin
                        phase_next      = PH_DONE;
                        error_code_next = dnsa_pkg::ST_NOT_RESP;
                    end
                    else if ((flag_word_reg & dnsa_pkg::RCODE_MASK) != '0)
                    begin
                        phase_next      = PH_DONE;
                        error_code_next = dnsa_pkg::ST_RCODE;
                    end
                    else if (questions_left_reg != '0)
                    begin
                        phase_next       = PH_QNAME;
                        skip_count_next  = '0;
                        field_index_next = '0;
                    end
                    else
                    begin
                        go_answers = 1'b1;
                    end
                end
            end
            PH_QNAME, PH_ANAME: ;
            PH_QFIXED:
            begin
                field_index_next = field_index_reg + 1'b1;
                if (field_index_reg == dnsa_pkg::QF_LAST)
                begin
                    field_index_next    = '0;
                    questions_left_next = questions_left_reg - 1'b1;
                    if (questions_left_next == '0)
                    begin
                        go_answers = 1'b1;
                    end
                    else
                    begin
                        phase_next      = PH_QNAME;
                        skip_count_next = '0;
                    end
                end
            end
            PH_AFIXED:
            begin
                case (field_index_reg)
                    dnsa_pkg::AF_TYPE_HI:  record_type_next[15:8]  = data_byte;
                    dnsa_pkg::AF_TYPE_LO:  record_type_next[7:0]   = data_byte;
                    dnsa_pkg::AF_CLASS_HI: record_class_next[15:8] = data_byte;
                    dnsa_pkg::AF_CLASS_LO: record_class_next[7:0]  = data_byte;
                    dnsa_pkg::AF_TTL_0, dnsa_pkg::AF_TTL_1,
                    dnsa_pkg::AF_TTL_2, dnsa_pkg::AF_TTL_3:
                        record_ttl_next = {record_ttl_reg[23:0], data_byte};
                    dnsa_pkg::AF_RDLEN_HI:
                        skip_count_next = {data_byte, {dnsa_pkg::BYTE_W{1'b0}}};
                    default: skip_count_next = rdlen;
                endcase
                field_index_next = field_index_reg + 1'b1;
                if (field_index_reg == dnsa_pkg::AF_LAST)
                begin
                    field_index_next = '0;
                    if (rdlen == '0)
                    begin
                        answers_left_next = answers_left_reg - 1'b1;
                        ans_count         = answers_left_next;
                        go_answers        = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_RDATA;
                    end
                end
            end
            PH_RDATA:
            begin
                if (is_a_in)
                begin
                    address_next = {address_reg[23:0], data_byte};
                end
                skip_count_next = skip_dec;
                if (skip_dec == '0)
                begin
                    field_index_next = fi_eff;
                    if (is_a_in && (fi_eff == dnsa_pkg::RD_A_LEN))
                    begin
                        phase_next      = PH_DONE;
                        error_code_next = dnsa_pkg::ST_FOUND;
                    end
                    else
                    begin
                        answers_left_next = answers_left_reg - 1'b1;
                        ans_count         = answers_left_next;
                        go_answers        = 1'b1;
                    end
                end
                else
                begin
                    // Hold the count saturated once past the A length
                    field_index_next = (fi_eff >= dnsa_pkg::RD_A_LEN)
                                       ? dnsa_pkg::RD_CAP : fi_eff + 1'b1;
                end
            end
            PH_DONE: ;
            default: ;
        endcase

        if (go_answers)
        begin
            if (ans_count == '0)
            begin
                phase_next      = PH_DONE;
                error_code_next = dnsa_pkg::ST_NO_A;
            end
            else
            begin
                phase_next       = PH_ANAME;
                skip_count_next  = '0;
                field_index_next = '0;
            end
        end
    end

    // Result as seen after this beat
    always_comb
    begin
        if (phase_next == PH_HEADER)
        begin
            result.status = dnsa_pkg::ST_SHORT;
        end
        else if (phase_next == PH_DONE)
        begin
            result.status = error_code_next;
        end
        else
        begin
            result.status = dnsa_pkg::ST_TRUNC;
        end
        if (result.status == dnsa_pkg::ST_FOUND)
        begin
            result.address      = address_next;
            result.time_to_live = record_ttl_next;
        end
        else
        begin
            result.address      = '0;
            result.time_to_live = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            header_index_reg   <= '0;
            field_index_reg    <= '0;
            questions_left_reg <= '0;
            answers_left_reg   <= '0;
            skip_count_reg     <= '0;
            error_code_reg     <= '0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                phase_reg          <= PH_HEADER;
                header_index_reg   <= '0;
                field_index_reg    <= '0;
                questions_left_reg <= '0;
                answers_left_reg   <= '0;
                skip_count_reg     <= '0;
                error_code_reg     <= '0;
            end
            else
            begin
                phase_reg          <= phase_next;
                header_index_reg   <= header_index_next;
                field_index_reg    <= field_index_next;
                questions_left_reg <= questions_left_next;
                answers_left_reg   <= answers_left_next;
                skip_count_reg     <= skip_count_next;
                error_code_reg     <= error_code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flag_word_reg    <= flag_word_next;
            record_type_reg  <= record_type_next;
            record_class_reg <= record_class_next;
            record_ttl_reg   <= record_ttl_next;
            address_reg      <= address_next;
        end
    end

endmodule

// ===== hdl/dnsa_out_stage.sv =====
module dnsa_out_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  dnsa_pkg::result_t              result,
    output logic                           space,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dnsa_pkg::STATUS_W-1:0]  status,
    output logic [dnsa_pkg::WORD_W-1:0]    address,
    output logic [dnsa_pkg::WORD_W-1:0]    time_to_live
);

    logic              valid_reg;
    logic              valid_next;
    dnsa_pkg::result_t result_reg;

    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = load || (valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = valid_reg;
    assign status       = result_reg.status;
    assign address      = result_reg.address;
    assign time_to_live = result_reg.time_to_live;

endmodule

// ===== hdl/dns_response_a_record_parser.sv =====
// DNS response A-record parser.
//
// Input channel (in_valid / in_ready): one packet byte per beat on data_byte,
// with last_byte high on the final byte of the packet. Bytes of one packet
// follow each other directly; the next packet starts with the beat after
// the last one.
// Output channel (out_valid / out_ready): exactly one result beat per packet,
// carrying status, address and time_to_live. address and time_to_live are
// zero unless status reports a found A record.
// The input register holds each accepted byte while the parser reads it; for
// the last byte the result is written into the output register, which drives
// out_valid.
// Throughput: one byte per cycle while no final byte waits for the output
// register; the parser state update is a single registered pass per byte.
// Reset: rst_n clears both valid flags and returns the parser to the header
// phase.
// Receiver stall: while a result sits unaccepted, non-final bytes keep
// flowing; only a final byte waits in the input register until the output
// register frees up, and in_ready drops for that time.
module dns_response_a_record_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dnsa_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dnsa_pkg::STATUS_W-1:0]  status,
    output logic [dnsa_pkg::WORD_W-1:0]    address,
    output logic [dnsa_pkg::WORD_W-1:0]    time_to_live
);

    logic                        held_valid;
    logic [dnsa_pkg::BYTE_W-1:0] held_byte;
    logic                        held_last;
    logic                        space;
    logic                        advance;
    logic                        load;
    dnsa_pkg::result_t           result;

    // Advance the held byte unless it ends a packet and the result slot is full
    assign advance = held_valid && (!held_last || space);
    assign load    = advance && held_last;

    dnsa_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .take       (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    dnsa_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (held_byte),
        .last_byte (held_last),
        .result    (result)
    );

    dnsa_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .result       (result),
        .space        (space),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .address      (address),
        .time_to_live (time_to_live)
    );

endmodule

// ===== hdl/dnsa_checker.sv =====
module dnsa_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [dnsa_pkg::STATUS_W-1:0]  status,
    input  logic [dnsa_pkg::WORD_W-1:0]    address,
    input  logic [dnsa_pkg::WORD_W-1:0]    time_to_live
);

    // Hold a stalled result beat unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(address) && $stable(time_to_live))
        else $error("result beat changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= dnsa_pkg::ST_NO_A)
        else $error("status code out of range");

    // Address and TTL only accompany a found record
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != dnsa_pkg::ST_FOUND)
            |-> (address == '0) && (time_to_live == '0))
        else $error("address or ttl set without a found record");

    // Input backpressure only comes from a full, stalled result slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

endmodule

bind dns_response_a_record_parser dnsa_checker u_dnsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .address      (address),
    .time_to_live (time_to_live)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // Clock, reset and run limit
    localparam int CYCLE_LIMIT = 400_000;
    localparam int RESET_CYCLES = 12;
    localparam int TAIL_CYCLES = 10;

    // Stop once both the byte budget and the packet count are reached.
    localparam int BYTE_BUDGET = 1300;
    localparam int PACKET_BUDGET = 20;

    // Receiver pacing modes
    localparam int RX_OPEN = 0;
    localparam int RX_PATTERN = 1;
    localparam int RX_SPARSE = 2;

    logic clk = 1'b0;
    logic rst_n;

    logic in_valid;
    logic in_ready;
    logic [dnsa_pkg::BYTE_W-1:0] data_byte;
    logic last_byte;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [dnsa_pkg::STATUS_W-1:0] status;
    logic [dnsa_pkg::WORD_W-1:0] address;
    logic [dnsa_pkg::WORD_W-1:0] time_to_live;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    dns_response_a_record_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .address      (address),
        .time_to_live (time_to_live)
    );

    // ------------------------------------------------------------------
    // Parser state mirror: advance one byte per accepted input beat.
    // ------------------------------------------------------------------
    typedef enum logic [2:0] {
        SCAN_HEADER,
        SCAN_QNAME,
        SCAN_QFIXED,
        SCAN_ANAME,
        SCAN_AFIXED,
        SCAN_RDATA,
        SCAN_DONE
    } scan_phase_t;

    scan_phase_t scan;
    logic [3:0] hdr_pos;
    logic [dnsa_pkg::COUNT_W-1:0] flags_w;
    logic [dnsa_pkg::COUNT_W-1:0] qd_left;
    logic [dnsa_pkg::COUNT_W-1:0] an_left;
    logic [dnsa_pkg::COUNT_W-1:0] skip_left;
    logic [3:0] fld_pos;
    logic [dnsa_pkg::COUNT_W-1:0] rr_type;
    logic [dnsa_pkg::COUNT_W-1:0] rr_class;
    logic [dnsa_pkg::WORD_W-1:0] rr_ttl;
    logic hit;
    logic [dnsa_pkg::WORD_W-1:0] hit_addr;
    logic [dnsa_pkg::WORD_W-1:0] hit_ttl;
    logic [dnsa_pkg::STATUS_W-1:0] fail_code;

    // Lookup results still owed by the block, oldest first.
    dnsa_pkg::result_t lookup_results[$];

    function automatic void clear_parse();
        scan = SCAN_HEADER;
        hdr_pos = '0;
        flags_w = '0;
        qd_left = '0;
        an_left = '0;
        skip_left = '0;
        fld_pos = '0;
        rr_type = '0;
        rr_class = '0;
        rr_ttl = '0;
        hit = 1'b0;
        hit_addr = '0;
        hit_ttl = '0;
        fail_code = '0;
    endfunction

    // Park the parser until the last byte; remember why.
    function automatic void close_packet(input logic [dnsa_pkg::STATUS_W-1:0] code);
        scan = SCAN_DONE;
        fail_code = code;
    endfunction

    function automatic void open_answers();
        if (an_left == '0)
            close_packet(dnsa_pkg::ST_NO_A);
        else
        begin
            scan = SCAN_ANAME;
            skip_left = '0;
            fld_pos = '0;
        end
    endfunction

    function automatic void next_answer();
        an_left = an_left - 1'b1;
        open_answers();
    endfunction

    // Walk one name byte; return 1 when the name is over. A pointer ends the
    // name on the byte after it.
    function automatic logic name_ends(input logic [dnsa_pkg::BYTE_W-1:0] b);
        if (fld_pos == dnsa_pkg::PTR_MARK)
            return 1'b1;
        if (skip_left != '0)
        begin
            skip_left = skip_left - 1'b1;
            return 1'b0;
        end
        if (b == '0)
            return 1'b1;
        if ((b & dnsa_pkg::PTR_MASK) == dnsa_pkg::PTR_MASK)
            fld_pos = dnsa_pkg::PTR_MARK;
        else
            skip_left = {8'h00, b};
        return 1'b0;
    endfunction

    function automatic void parse_byte(input logic [dnsa_pkg::BYTE_W-1:0] b,
                                       input logic lst,
                                       output logic has_res,
                                       output dnsa_pkg::result_t res);
        logic [dnsa_pkg::STATUS_W-1:0] st;
        has_res = 1'b0;
        res = '0;
        // In rdata the position counts bytes already taken, starting at one.
        if (scan == SCAN_RDATA && fld_pos == '0)
            fld_pos = dnsa_pkg::RD_FIRST;
        case (scan)
            SCAN_HEADER:
            begin
                case (hdr_pos)
                    dnsa_pkg::HDR_FLAGS_HI: flags_w = {b, 8'h00};
                    dnsa_pkg::HDR_FLAGS_LO: flags_w = flags_w | {8'h00, b};
                    dnsa_pkg::HDR_QD_HI:    qd_left = {b, 8'h00};
                    dnsa_pkg::HDR_QD_LO:    qd_left = qd_left | {8'h00, b};
                    dnsa_pkg::HDR_AN_HI:    an_left = {b, 8'h00};
                    dnsa_pkg::HDR_AN_LO:    an_left = an_left | {8'h00, b};
                    default: ;
                endcase
                hdr_pos = hdr_pos + 1'b1;
                if (hdr_pos == dnsa_pkg::HDR_LAST + 4'd1)
                begin
                    // QR is checked ahead of the response code.
                    if ((flags_w & dnsa_pkg::QR_BIT) == '0)
                        close_packet(dnsa_pkg::ST_NOT_RESP);
                    else if ((flags_w & dnsa_pkg::RCODE_MASK) != '0)
                        close_packet(dnsa_pkg::ST_RCODE);
                    else if (qd_left != '0)
                    begin
                        scan = SCAN_QNAME;
                        skip_left = '0;
                        fld_pos = '0;
                    end
                    else
                        open_answers();
                end
            end
            SCAN_QNAME:
            begin
                if (name_ends(b))
                begin
                    scan = SCAN_QFIXED;
                    skip_left = '0;
                    fld_pos = '0;
                end
            end
            SCAN_QFIXED:
            begin
                fld_pos = fld_pos + 1'b1;
                if (fld_pos > dnsa_pkg::QF_LAST)
                begin
                    fld_pos = '0;
                    qd_left = qd_left - 1'b1;
                    if (qd_left == '0)
                        open_answers();
                    else
                    begin
                        scan = SCAN_QNAME;
                        skip_left = '0;
                    end
                end
            end
            SCAN_ANAME:
            begin
                if (name_ends(b))
                begin
                    scan = SCAN_AFIXED;
                    skip_left = '0;
                    fld_pos = '0;
                end
            end
            SCAN_AFIXED:
            begin
                case (fld_pos)
                    dnsa_pkg::AF_TYPE_HI:  rr_type = {b, 8'h00};
                    dnsa_pkg::AF_TYPE_LO:  rr_type = rr_type | {8'h00, b};
                    dnsa_pkg::AF_CLASS_HI: rr_class = {b, 8'h00};
                    dnsa_pkg::AF_CLASS_LO: rr_class = rr_class | {8'h00, b};
                    dnsa_pkg::AF_TTL_0, dnsa_pkg::AF_TTL_1,
                    dnsa_pkg::AF_TTL_2, dnsa_pkg::AF_TTL_3:
                        rr_ttl = {rr_ttl[23:0], b};
                    dnsa_pkg::AF_RDLEN_HI: skip_left = {b, 8'h00};
                    default:               skip_left = skip_left | {8'h00, b};
                endcase
                fld_pos = fld_pos + 1'b1;
                if (fld_pos > dnsa_pkg::AF_LAST)
                begin
                    fld_pos = '0;
                    hit_addr = '0;
                    if (skip_left == '0)
                        next_answer();
                    else
                        scan = SCAN_RDATA;
                end
            end
            SCAN_RDATA:
            begin
                if (rr_type == dnsa_pkg::TYPE_A && rr_class == dnsa_pkg::CLASS_IN)
                    hit_addr = {hit_addr[23:0], b};
                skip_left = skip_left - 1'b1;
                if (skip_left == '0)
                begin
                    // Only an A/IN record with exactly four rdata bytes matches.
                    if (rr_type == dnsa_pkg::TYPE_A && rr_class == dnsa_pkg::CLASS_IN
                        && fld_pos == dnsa_pkg::RD_A_LEN)
                    begin
                        hit = 1'b1;
                        hit_ttl = rr_ttl;
                        close_packet(dnsa_pkg::ST_FOUND);
                    end
                    else
                        next_answer();
                end
                else
                begin
                    fld_pos = fld_pos + 1'b1;
                    if (fld_pos > dnsa_pkg::RD_A_LEN)
                        fld_pos = dnsa_pkg::RD_CAP;
                end
            end
            default: ;
        endcase

        if (lst)
        begin
            // A completed match beats any later truncation.
            if (hit)
                st = dnsa_pkg::ST_FOUND;
            else if (scan == SCAN_HEADER)
                st = dnsa_pkg::ST_SHORT;
            else if (scan == SCAN_DONE)
                st = fail_code;
            else
                st = dnsa_pkg::ST_TRUNC;
            res.status = st;
            res.address = (st == dnsa_pkg::ST_FOUND) ? hit_addr : '0;
            res.time_to_live = (st == dnsa_pkg::ST_FOUND) ? hit_ttl : '0;
            has_res = 1'b1;
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed bytes: a one-byte packet, a header with QR clear and a
    // nonzero rcode (QR wins), and an all-ones header (rcode error).
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [dnsa_pkg::BYTE_W-1:0]   data;
        logic                          last;
        logic                          known;
        logic [dnsa_pkg::STATUS_W-1:0] status;
    } stim_row_t;

    localparam int DIR_ROWS = 25;

    stim_row_t dir_table [DIR_ROWS] = '{
        '{8'hFF, 1'b1, 1'b1, dnsa_pkg::ST_SHORT},
        // QR clear, rcode 0xF
        '{8'h00, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'h7F, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'h00, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'h00, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'h00, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'h01, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'h00, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'h00, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'h00, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'h00, 1'b1, 1'b1, dnsa_pkg::ST_NOT_RESP},
        // every bit of the header set
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b0, 1'b0, dnsa_pkg::ST_FOUND},
        '{8'hFF, 1'b1, 1'b1, dnsa_pkg::ST_RCODE}
    };

    // ------------------------------------------------------------------
    // Packet builder: mostly well-formed responses with random content,
    // plus noise, bad flags, huge counts and cut-short packets.
    // ------------------------------------------------------------------
    logic [dnsa_pkg::BYTE_W-1:0] pkt_bytes[$];

    function automatic void push_word16(input logic [15:0] w);
        pkt_bytes.push_back(w[15:8]);
        pkt_bytes.push_back(w[7:0]);
    endfunction

    function automatic void add_name();
        int shape;
        int len;
        shape = $urandom_range(0, 9);
        if (shape == 0)
            pkt_bytes.push_back(8'h00);
        else if (shape <= 3)
        begin
            pkt_bytes.push_back(dnsa_pkg::PTR_MASK | 8'($urandom_range(0, 63)));
            pkt_bytes.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                // Now and then a length byte with one top bit set.
                len = ($urandom_range(0, 119) == 0) ? $urandom_range(64, 191)
                                                    : $urandom_range(1, 10);
                pkt_bytes.push_back(8'(len));
                repeat (len) pkt_bytes.push_back(8'($urandom));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                pkt_bytes.push_back(dnsa_pkg::PTR_MASK | 8'($urandom_range(0, 63)));
                pkt_bytes.push_back(8'($urandom));
            end
            else
                pkt_bytes.push_back(8'h00);
        end
    endfunction

    function automatic void build_packet();
        int form;
        int qd_n;
        int an_n;
        int rd_n;
        int cut;
        logic [15:0] flags;
        logic [15:0] qd;
        logic [15:0] an;
        logic [15:0] rdlen;
        pkt_bytes.delete();
        form = $urandom_range(0, 19);
        if (form == 0)
        begin
            // noise packet, usually shorter than a header
            repeat ($urandom_range(1, 16)) pkt_bytes.push_back(8'($urandom));
            return;
        end
        flags = 16'($urandom);
        qd = 16'($urandom_range(0, 2));
        an = 16'($urandom_range(0, 3));
        if (form != 1)
            flags = (flags | dnsa_pkg::QR_BIT) & ~dnsa_pkg::RCODE_MASK;
        if (form == 2)
        begin
            qd = 16'($urandom);
            an = 16'($urandom);
        end
        push_word16(16'($urandom));
        push_word16(flags);
        push_word16(qd);
        push_word16(an);
        push_word16(16'($urandom));
        push_word16(16'($urandom));

        qd_n = (qd > 16'd3) ? 3 : int'(qd);
        an_n = (an > 16'd4) ? 4 : int'(an);
        repeat (qd_n)
        begin
            add_name();
            push_word16(16'($urandom));
            push_word16(16'($urandom));
        end
        for (int k = 0; k < an_n; k++)
        begin
            add_name();
            push_word16(($urandom_range(0, 9) < 7) ? dnsa_pkg::TYPE_A : 16'($urandom));
            push_word16(($urandom_range(0, 9) < 8) ? dnsa_pkg::CLASS_IN : 16'($urandom));
            push_word16(16'($urandom));
            push_word16(16'($urandom));
            case ($urandom_range(0, 9))
                0:       rdlen = 16'($urandom);
                1, 2:    rdlen = 16'($urandom_range(0, 8));
                default: rdlen = 16'(dnsa_pkg::RD_A_LEN);
            endcase
            push_word16(rdlen);
            // Long rdata is cut off, which ends the packet inside it.
            rd_n = (rdlen > 16'd12) ? $urandom_range(0, 12) : int'(rdlen);
            repeat (rd_n) pkt_bytes.push_back(8'($urandom));
            if (rd_n != int'(rdlen))
                break;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) pkt_bytes.push_back(8'($urandom));
        if (pkt_bytes.size() > 1 && $urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, pkt_bytes.size() - 1);
            while (pkt_bytes.size() > cut)
                void'(pkt_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps between them.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int bytes_sent = 0;
    int packets_sent = 0;
    int mismatch_cnt = 0;

    // Offer one beat, hold it until accepted, then advance the mirror.
    // A typed-in expectation, where given, replaces the mirror's result.
    task automatic send_byte(input logic [dnsa_pkg::BYTE_W-1:0] b, input logic lst,
                             input logic known, input dnsa_pkg::result_t typed);
        int pause;
        logic has_res;
        dnsa_pkg::result_t res;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            pause = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (pause != 0)
            begin
                in_valid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        bytes_sent++;
        parse_byte(b, lst, has_res, res);
        if (has_res)
            lookup_results.push_back(known ? typed : res);
    endtask

    // ------------------------------------------------------------------
    // Receiver: switch between always-ready, a fixed stall pattern and a
    // sparse random ready; check each result beat against the oldest
    // expectation.
    // ------------------------------------------------------------------
    int rx_mode = RX_OPEN;
    int rx_left = 0;
    logic [7:0] pace_cnt = '0;
    dnsa_pkg::result_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (lookup_results.size() == 0)
            begin
                $error("status: expected no result beat, got %0d", status);
                mismatch_cnt++;
            end
            else
            begin
                want = lookup_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_cnt++;
                end
                if (address !== want.address)
                begin
                    $error("address: expected %h, got %h", want.address, address);
                    mismatch_cnt++;
                end
                if (time_to_live !== want.time_to_live)
                begin
                    $error("time_to_live: expected %h, got %h",
                           want.time_to_live, time_to_live);
                    mismatch_cnt++;
                end
            end
        end

        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(RX_OPEN, RX_SPARSE);
            rx_left = $urandom_range(20, 150);
        end
        else
            rx_left--;
        pace_cnt = pace_cnt + 1'b1;
        case (rx_mode)
            RX_OPEN:    out_ready <= 1'b1;
            RX_PATTERN: out_ready <= pace_cnt[1] | (pace_cnt[4:3] == 2'b11);
            default:    out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog: give up at a generous cycle count.
    int cycle_cnt = 0;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        clear_parse();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(dir_table[i].data, dir_table[i].last, dir_table[i].known,
                      '{status: dir_table[i].status, address: '0, time_to_live: '0});

        while (bytes_sent < BYTE_BUDGET || packets_sent < PACKET_BUDGET)
        begin
            build_packet();
            for (int k = 0; k < pkt_bytes.size(); k++)
                send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1, 1'b0, '0);
            packets_sent++;
        end
        in_valid <= 1'b0;

        // Drain, then keep clocking to catch any stray beat.
        while (lookup_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
